// ===== sv/crd_pkg.sv =====
// ----------------------------------------------------------------------------
// crd_pkg: shared types and microcode for the cubic resample decimator
// Widths, datapath select codes, control word layout and the program ROM.
// ----------------------------------------------------------------------------
package crd_pkg;

  localparam int SAMPLE_W = 16;
  localparam int PERIOD_W = 7;
  localparam int HIST_N   = 4;
  localparam int X_W      = 16;
  localparam int CNT_W    = $clog2(X_W);
  localparam int W_W      = X_W + 4;
  localparam int MB_W     = SAMPLE_W + 1;
  localparam int PROD_W   = W_W + MB_W;
  localparam int ACC_W    = PROD_W + $clog2(HIST_N);
  localparam int STEP_W   = 4;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [PERIOD_W-1:0]        period_t;
  typedef logic [STEP_W-1:0]          step_t;

  // Program step addresses
  localparam step_t STEP_DIV    = step_t'(0);
  localparam step_t STEP_MUL_XX = step_t'(1);
  localparam step_t STEP_RND_X2 = step_t'(2);
  localparam step_t STEP_MUL_X3 = step_t'(3);
  localparam step_t STEP_RND_X3 = step_t'(4);
  localparam step_t STEP_WGT    = step_t'(5);
  localparam step_t STEP_MAC0   = step_t'(6);
  localparam step_t STEP_MAC1   = step_t'(7);
  localparam step_t STEP_MAC2   = step_t'(8);
  localparam step_t STEP_MAC3   = step_t'(9);
  localparam step_t STEP_ACC    = step_t'(10);
  localparam step_t STEP_FIN    = step_t'(11);

  typedef enum logic [2:0] {
    MS_NONE,
    MS_XX,
    MS_X2X,
    MS_WH0,
    MS_WH1,
    MS_WH2,
    MS_WH3
  } mul_sel_e;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_X2,
    RD_X3
  } rnd_dst_e;

  typedef enum logic [1:0] {
    AO_HOLD,
    AO_CLEAR,
    AO_ADD
  } acc_op_e;

  typedef struct packed {
    logic     div_step;
    mul_sel_e mul_sel;
    logic     prod_en;
    rnd_dst_e rnd_dst;
    logic     w_en;
    acc_op_e  acc_op;
    logic     loop;
    logic     fin;
  } uword_t;

  // Program ROM: one control word per step
  function automatic uword_t urom(input step_t step);
    uword_t w;
    w = '0;
    case (step)
      STEP_DIV: begin
        w.div_step = 1'b1;
        w.loop     = 1'b1;
      end
      STEP_MUL_XX: begin
        w.mul_sel = MS_XX;
        w.prod_en = 1'b1;
      end
      STEP_RND_X2: w.rnd_dst = RD_X2;
      STEP_MUL_X3: begin
        w.mul_sel = MS_X2X;
        w.prod_en = 1'b1;
      end
      STEP_RND_X3: w.rnd_dst = RD_X3;
      STEP_WGT:    w.w_en = 1'b1;
      STEP_MAC0: begin
        w.mul_sel = MS_WH0;
        w.prod_en = 1'b1;
        w.acc_op  = AO_CLEAR;
      end
      STEP_MAC1: begin
        w.mul_sel = MS_WH1;
        w.prod_en = 1'b1;
        w.acc_op  = AO_ADD;
      end
      STEP_MAC2: begin
        w.mul_sel = MS_WH2;
        w.prod_en = 1'b1;
        w.acc_op  = AO_ADD;
      end
      STEP_MAC3: begin
        w.mul_sel = MS_WH3;
        w.prod_en = 1'b1;
        w.acc_op  = AO_ADD;
      end
      STEP_ACC:    w.acc_op = AO_ADD;
      default:     w.fin = 1'b1;
    endcase
    return w;
  endfunction

endpackage

// ===== sv/crd_in_if.sv =====
// ----------------------------------------------------------------------------
// crd_in_if: input sample channel
// Valid/ready request channel carrying one signed audio sample.
// ----------------------------------------------------------------------------
interface crd_in_if;
  import crd_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

// ===== sv/crd_out_if.sv =====
// ----------------------------------------------------------------------------
// crd_out_if: output sample channel
// Valid/ready request channel carrying one interpolated sample.
// ----------------------------------------------------------------------------
interface crd_out_if;
  import crd_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

// ===== sv/cubic_resample_decimator_core.sv =====
// ----------------------------------------------------------------------------
// cubic_resample_decimator_core: Catmull-Rom cubic resampling decimator
// Microcoded sequencer around a shared divide/multiply datapath.
// ----------------------------------------------------------------------------
// Each accepted request carries one signed 16-bit sample and yields exactly
// one signed 16-bit result. With hold_period at zero the sample passes through
// unchanged and the phase and history are left alone. Otherwise every sample
// advances a phase counter; when it reaches the period the sample shifts into
// a four-deep history and the phase returns to zero. The result is the
// Catmull-Rom cubic between the two middle history samples at
// x = phase / period, rounded half up and saturated. An interpolating sample
// occupies the block while it takes the request, runs the restoring divider
// that forms x (one quotient bit per cycle), steps through
// the shared multiplier for x^2, x^3, the weights and the four products, and
// then rounds, saturates and loads the output register. A pass-through sample
// goes straight to that final step. A finished result waits in the output register, so the
// next request is taken while it is still pending; only the final step holds
// when the previous result has not yet been taken. Write hold_period only
// while the block is idle.
// ----------------------------------------------------------------------------
module cubic_resample_decimator_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  crd_pkg::period_t cfg_wdata_i,
  crd_in_if.sink           in_i,
  crd_out_if.source        out_o
);
  import crd_pkg::*;

  period_t hold_period_q;
  period_t phase_q, phase_d;
  sample_t hist_q [HIST_N];
  sample_t hist_d [HIST_N];
  sample_t sample_q;
  sample_t out_q;
  sample_t result;

  logic    busy_q, busy_d;
  logic    bypass_q, bypass_d;
  logic    out_valid_q, out_valid_d;
  step_t   pc_q, pc_d;

  logic    in_acc;
  logic    out_load;
  logic    bypass_in;
  logic    div_last;
  period_t phase_inc;
  uword_t  uw;
  uword_t  dp_uw;

  assign in_i.ready       = !busy_q;
  assign in_acc           = in_i.valid && in_i.ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_q;

  assign bypass_in = hold_period_q == '0;

  // Fetch the control word; drive no-ops into the datapath while idle
  assign uw    = urom(pc_q);
  assign dp_uw = busy_q ? uw : '0;

  // Advance phase on an accepted interpolating sample; shift history when it wraps
  assign phase_inc = phase_q + PERIOD_W'(1);

  always_comb begin
    phase_d = phase_q;
    hist_d  = hist_q;
    if (in_acc && !bypass_in) begin
      if (phase_inc >= hold_period_q) begin
        phase_d = '0;
        for (int k = 0; k < HIST_N - 1; k++) begin
          hist_d[k] = hist_q[k+1];
        end
        hist_d[HIST_N-1] = in_i.sample_in;
      end else begin
        phase_d = phase_inc;
      end
    end
  end

  // Sequencer: step counter, loop on the divide step, hold at the final step
  always_comb begin
    busy_d      = busy_q;
    bypass_d    = bypass_q;
    pc_d        = pc_q;
    out_valid_d = out_valid_q;
    out_load    = 1'b0;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (in_acc) begin
      busy_d   = 1'b1;
      bypass_d = bypass_in;
      pc_d     = bypass_in ? STEP_FIN : STEP_DIV;
    end else if (busy_q) begin
      if (uw.fin) begin
        if (!out_valid_q || out_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          busy_d      = 1'b0;
        end
      end else if (!(uw.loop && !div_last)) begin
        pc_d = pc_q + STEP_W'(1);
      end
    end
  end

  crd_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_acc),
    .ph_start_i (phase_d),
    .period_i   (hold_period_q),
    .hist_i     (hist_q),
    .uw_i       (dp_uw),
    .div_last_o (div_last),
    .result_o   (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_period_q <= '0;
      phase_q       <= '0;
      hist_q        <= '{default: '0};
      busy_q        <= 1'b0;
      bypass_q      <= 1'b0;
      pc_q          <= STEP_DIV;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        hold_period_q <= cfg_wdata_i;
      end
      phase_q     <= phase_d;
      hist_q      <= hist_d;
      busy_q      <= busy_d;
      bypass_q    <= bypass_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: the captured sample and the output slot
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q <= in_i.sample_in;
    end
    if (out_load) begin
      out_q <= bypass_q ? sample_q : result;
    end
  end

  // Finishing an item always leaves a result in the output slot
  a_fin_loads_out: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> out_valid_q
  ) else $error("sequencer went idle without loading a result");

  // A pass-through sample never runs the arithmetic program
  a_bypass_at_fin: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    busy_q && bypass_q |-> pc_q == STEP_FIN
  ) else $error("pass-through sample entered the arithmetic program");

  // The multiply steps start only after all quotient bits are formed
  a_div_complete: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    busy_q && pc_q == STEP_MUL_XX |-> $past(div_last)
  ) else $error("left the divide step before the last quotient bit");

endmodule

// ===== sv/crd_datapath.sv =====
// ----------------------------------------------------------------------------
// crd_datapath: divide, weight and multiply-accumulate datapath
// Restoring divider, one shared multiplier and an accumulator, all driven
// by the current control word.
// ----------------------------------------------------------------------------
module crd_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  crd_pkg::period_t ph_start_i,
  input  crd_pkg::period_t period_i,
  input  crd_pkg::sample_t hist_i [crd_pkg::HIST_N],
  input  crd_pkg::uword_t  uw_i,
  output logic             div_last_o,
  output crd_pkg::sample_t result_o
);
  import crd_pkg::*;

  localparam logic signed [W_W-1:0]   W_ONE    = W_W'(2 ** (X_W + 1));
  localparam logic [2*X_W:0]          RND_HALF = (2*X_W+1)'(2 ** (X_W - 1));
  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(2 ** X_W);
  localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(2 ** (SAMPLE_W - 1) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO   = ACC_W'(-(2 ** (SAMPLE_W - 1)));

  logic [PERIOD_W:0]         rem_q;
  logic [CNT_W-1:0]          cnt_q;
  logic [X_W-1:0]            x_q, x2_q, x3_q;
  logic signed [W_W-1:0]     w_q [HIST_N];
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]   acc_q;

  logic [PERIOD_W:0]         rem_sh;
  logic                      qbit;
  logic signed [W_W-1:0]     ex, ex2, ex3;
  logic signed [W_W-1:0]     w_d [HIST_N];
  logic signed [W_W-1:0]     ma;
  logic signed [MB_W-1:0]    mb;
  logic signed [PROD_W-1:0]  prod_d;
  logic [2*X_W:0]            rnd_sum;
  logic signed [ACC_W-1:0]   acc_rnd, acc_sh;

  // Divider: one quotient bit per step of phase * 2^16 / period
  assign rem_sh     = {rem_q[PERIOD_W-1:0], 1'b0};
  assign qbit       = rem_sh >= {1'b0, period_i};
  assign div_last_o = cnt_q == CNT_W'(X_W - 1);

  // Doubled Catmull-Rom weights in units of 2^-16
  assign ex  = $signed({{(W_W-X_W){1'b0}}, x_q});
  assign ex2 = $signed({{(W_W-X_W){1'b0}}, x2_q});
  assign ex3 = $signed({{(W_W-X_W){1'b0}}, x3_q});

  always_comb begin
    w_d[0] = (ex2 <<< 1) - ex3 - ex;
    w_d[1] = (ex3 <<< 1) + ex3 - (ex2 <<< 2) - ex2 + W_ONE;
    w_d[2] = (ex2 <<< 2) + ex - (ex3 <<< 1) - ex3;
    w_d[3] = ex3 - ex2;
  end

  // Shared multiplier operand select
  always_comb begin
    case (uw_i.mul_sel)
      MS_XX: begin
        ma = ex;
        mb = $signed({1'b0, x_q});
      end
      MS_X2X: begin
        ma = ex2;
        mb = $signed({1'b0, x_q});
      end
      MS_WH0: begin
        ma = w_q[0];
        mb = MB_W'(hist_i[0]);
      end
      MS_WH1: begin
        ma = w_q[1];
        mb = MB_W'(hist_i[1]);
      end
      MS_WH2: begin
        ma = w_q[2];
        mb = MB_W'(hist_i[2]);
      end
      MS_WH3: begin
        ma = w_q[3];
        mb = MB_W'(hist_i[3]);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod_d  = ma * mb;
  assign rnd_sum = {1'b0, prod_q[2*X_W-1:0]} + RND_HALF;

  // Round half up, then saturate
  assign acc_rnd = acc_q + ACC_HALF;
  assign acc_sh  = acc_rnd >>> (X_W + 1);

  always_comb begin
    if (acc_sh > SAT_HI) begin
      result_o = SAT_HI[SAMPLE_W-1:0];
    end else if (acc_sh < SAT_LO) begin
      result_o = SAT_LO[SAMPLE_W-1:0];
    end else begin
      result_o = acc_sh[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= '0;
    end else if (uw_i.div_step) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, ph_start_i};
    end else if (uw_i.div_step) begin
      rem_q <= qbit ? rem_sh - {1'b0, period_i} : rem_sh;
      x_q   <= {x_q[X_W-2:0], qbit};
    end
    if (uw_i.prod_en) begin
      prod_q <= prod_d;
    end
    case (uw_i.rnd_dst)
      RD_X2:   x2_q <= rnd_sum[2*X_W-1:X_W];
      RD_X3:   x3_q <= rnd_sum[2*X_W-1:X_W];
      default: ;
    endcase
    if (uw_i.w_en) begin
      w_q <= w_d;
    end
    case (uw_i.acc_op)
      AO_CLEAR: acc_q <= '0;
      AO_ADD:   acc_q <= acc_q + ACC_W'(prod_q);
      default:  ;
    endcase
  end

endmodule
